>>> rtl/core/soa_pkg.sv
// Package for the slab object allocator: payload structs, status and command codes,
// register indexes and the sequencer state type. No dependencies.
package soa_pkg;

  localparam int unsigned DIV_W    = 17;
  localparam int unsigned IN_USE_W = 13;
  localparam int unsigned FIELD_AW = 32;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_NO_FRAME  = 2'd1;
  localparam logic [1:0] STATUS_NOTHING   = 2'd2;
  localparam logic [1:0] STATUS_TOO_SMALL = 2'd3;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [2:0] REG_OBJECT_SIZE   = 3'd0;
  localparam logic [2:0] REG_SLAB_BYTES    = 3'd1;
  localparam logic [2:0] REG_HEADER_BYTES  = 3'd2;
  localparam logic [2:0] REG_POINTER_BYTES = 3'd3;
  localparam logic [2:0] REG_POOL_BASE     = 3'd4;

  typedef struct packed {
    logic        cmd;
    logic [31:0] freed_address;
  } req_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [31:0]         object_address;
    logic [IN_USE_W-1:0] objects_in_use;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_BASE,
    ST_FILL,
    ST_POP_RD,
    ST_POP_WR,
    ST_PUSH
  } state_e;

endpackage

>>> rtl/core/soa_div.sv
// Iterative restoring divider for the slot count, one quotient bit per cycle.
// Depends on soa_pkg for the operand width.
module soa_div import soa_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] num_i,
  input  logic [DIV_W-1:0] den_i,
  output logic             done_o,
  output logic [DIV_W-1:0] quo_o
);

  localparam int unsigned CW = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] rem_q, quo_q, den_q;
  logic [CW-1:0]    cnt_q;
  logic             done_q;
  logic [DIV_W:0]   trial;

  assign trial = {rem_q, quo_q[DIV_W-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CW'(DIV_W);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (cnt_q != '0) begin
      if (trial >= {1'b0, den_q}) begin
        rem_q <= DIV_W'(trial - {1'b0, den_q});
        quo_q <= {quo_q[DIV_W-2:0], 1'b1};
      end else begin
        rem_q <= trial[DIV_W-1:0];
        quo_q <= {quo_q[DIV_W-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

>>> rtl/core/slab_object_allocator.sv
// Slab object allocator top level: APB register file, list bookkeeping, free-stack
// memory and the sequencer. Depends on soa_pkg and soa_div.
//
// An item is taken when start is high and busy is low; its one result appears on
// result_o with result_valid_o high for a single cycle and cannot be stalled. An
// allocate served from an existing slab goes through the POP_RD and POP_WR states
// before its result, and a release through the PUSH state. An allocate that carves
// a new frame first runs the slot count through the serial divider, then the MUL
// and BASE address steps, then writes the new slab's free stack one slot per cycle
// through the single memory write port, then pops a slot as an existing-slab allocate does.
// Error results come in the cycle after accept, except a slot count of zero found
// by the divider, which comes once the divider finishes.
// The free stacks are not cleared at reset.
module slab_object_allocator import soa_pkg::*; #(
  parameter int unsigned MAX_SLABS         = 16,
  parameter int unsigned MAX_OBJS_PER_SLAB = 256,
  parameter int unsigned ADDR_WIDTH        = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  req_t        req_i,
  output logic        result_valid_o,
  output rsp_t        result_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned SW  = (MAX_SLABS > 1) ? $clog2(MAX_SLABS) : 1;
  localparam int unsigned LW  = $clog2(MAX_SLABS + 1);
  localparam int unsigned TW  = $clog2(MAX_OBJS_PER_SLAB + 1);
  localparam int unsigned MD  = MAX_SLABS * MAX_OBJS_PER_SLAB;
  localparam int unsigned MAW = (MD > 1) ? $clog2(MD) : 1;
  localparam int unsigned AW  = ADDR_WIDTH;

  // Configuration registers.
  logic [15:0] obj_size_q;
  logic [16:0] slab_bytes_q;
  logic [10:0] hdr_bytes_q;
  logic [3:0]  ptr_bytes_q;
  logic [31:0] pool_base_q;

  logic cfg_we;
  assign cfg_we = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      obj_size_q   <= 16'd64;
      slab_bytes_q <= 17'd4096;
      hdr_bytes_q  <= 11'd48;
      ptr_bytes_q  <= 4'd8;
      pool_base_q  <= '0;
    end else if (cfg_we) begin
      case (paddr[4:2])
        REG_OBJECT_SIZE:   obj_size_q   <= pwdata[15:0];
        REG_SLAB_BYTES:    slab_bytes_q <= pwdata[16:0];
        REG_HEADER_BYTES:  hdr_bytes_q  <= pwdata[10:0];
        REG_POINTER_BYTES: ptr_bytes_q  <= pwdata[3:0];
        REG_POOL_BASE:     pool_base_q  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_OBJECT_SIZE:   prdata = {16'd0, obj_size_q};
      REG_SLAB_BYTES:    prdata = {15'd0, slab_bytes_q};
      REG_HEADER_BYTES:  prdata = {21'd0, hdr_bytes_q};
      REG_POINTER_BYTES: prdata = {28'd0, ptr_bytes_q};
      REG_POOL_BASE:     prdata = pool_base_q;
      default:           prdata = '0;
    endcase
  end

  // Slot count operands.
  logic [11:0]      used_bytes;
  logic [DIV_W-1:0] div_den, div_num, div_quo;
  logic             geom_bad, div_start, div_done;
  logic [TW-1:0]    div_n;

  assign used_bytes = 12'(hdr_bytes_q) + 12'(ptr_bytes_q);
  assign div_den    = DIV_W'(obj_size_q) + DIV_W'(ptr_bytes_q);
  assign geom_bad   = (slab_bytes_q <= DIV_W'(used_bytes)) || (div_den == '0);
  assign div_num    = slab_bytes_q - DIV_W'(used_bytes);
  assign div_n      = (div_quo > DIV_W'(MAX_OBJS_PER_SLAB)) ? TW'(MAX_OBJS_PER_SLAB)
                                                             : TW'(div_quo);

  soa_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  // Slab lists and per-slab state.
  logic [SW-1:0] empty_list_q [MAX_SLABS];
  logic [SW-1:0] part_list_q  [MAX_SLABS];
  logic [SW-1:0] full_list_q  [MAX_SLABS];
  logic [TW-1:0] slab_top_q   [MAX_SLABS];
  logic [LW-1:0] el_q, pl_q, fl_q, el_d, pl_d, fl_d;
  logic [LW-1:0] frames_q;
  logic [TW-1:0] spp_q;
  logic [IN_USE_W-1:0] in_use_q, in_use_d;

  logic [LW-1:0] el_m1, pl_m1, fl_m1;
  logic [SW-1:0] empty_head, part_head, full_head;
  assign el_m1      = el_q - 1'b1;
  assign pl_m1      = pl_q - 1'b1;
  assign fl_m1      = fl_q - 1'b1;
  assign empty_head = empty_list_q[el_m1[SW-1:0]];
  assign part_head  = part_list_q[pl_m1[SW-1:0]];
  assign full_head  = full_list_q[fl_m1[SW-1:0]];

  // Free-stack memory.
  logic [AW-1:0] slot_mem [MD];
  logic [AW-1:0] rd_data_q;

  // Sequencer registers.
  state_e        state_q, state_d;
  logic [31:0]   freed_q;
  logic [SW-1:0] cur_q;
  logic [TW-1:0] n_q, fill_i_q;
  logic [AW-1:0] frame_off_q, osn_q, fill_addr_q;
  logic          res_valid_q;
  rsp_t          res_q;

  // Control produced by the sequencer.
  typedef struct packed {
    logic e_pop, p_pop, f_pop;
    logic e_push, p_push, f_push;
    logic [SW-1:0] push_id;
  } list_op_t;

  list_op_t      lop;
  logic          top_we, mem_we, mem_re, res_we, carve_done, cap_div;
  logic [SW-1:0] top_wi;
  logic [TW-1:0] top_wd, top_cur, top_dec;
  logic [TW:0]   top_inc;
  logic [MAW-1:0] mem_wa, mem_ra;
  logic [AW-1:0] mem_wd;
  rsp_t          res_d;

  function automatic logic [MAW-1:0] slot_idx(input logic [SW-1:0] s, input logic [TW-1:0] e);
    logic [TW-1:0] ec;
    ec = (e < TW'(MAX_OBJS_PER_SLAB)) ? e : TW'(MAX_OBJS_PER_SLAB - 1);
    return MAW'(s) * MAW'(MAX_OBJS_PER_SLAB) + MAW'(ec);
  endfunction

  assign top_cur = slab_top_q[(state_q == ST_POP_WR) ? cur_q : part_head];
  assign top_inc = {1'b0, top_cur} + 1'b1;
  assign top_dec = (top_cur != '0) ? top_cur - 1'b1 : '0;

  always_comb begin
    state_d    = state_q;
    lop        = '0;
    div_start  = 1'b0;
    cap_div    = 1'b0;
    top_we     = 1'b0;
    top_wi     = part_head;
    top_wd     = '0;
    mem_we     = 1'b0;
    mem_wa     = slot_idx(frames_q[SW-1:0], fill_i_q);
    mem_wd     = fill_addr_q;
    mem_re     = 1'b0;
    mem_ra     = slot_idx(part_head, top_cur);
    res_we     = 1'b0;
    res_d      = '{status: STATUS_OK, object_address: '0, objects_in_use: in_use_q};
    in_use_d   = in_use_q;
    carve_done = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          if (req_i.cmd == CMD_ALLOC) begin
            priority if (pl_q != '0) begin
              state_d = ST_POP_RD;
            end else if (el_q != '0) begin
              lop.e_pop   = 1'b1;
              lop.p_push  = 1'b1;
              lop.push_id = empty_head;
              state_d     = ST_POP_RD;
            end else if (frames_q >= LW'(MAX_SLABS)) begin
              res_we       = 1'b1;
              res_d.status = STATUS_NO_FRAME;
            end else if (geom_bad) begin
              res_we       = 1'b1;
              res_d.status = STATUS_TOO_SMALL;
            end else begin
              div_start = 1'b1;
              state_d   = ST_DIV;
            end
          end else begin
            priority if (pl_q != '0) begin
              state_d = ST_PUSH;
            end else if (fl_q != '0) begin
              lop.f_pop   = 1'b1;
              lop.p_push  = 1'b1;
              lop.push_id = full_head;
              state_d     = ST_PUSH;
            end else begin
              res_we       = 1'b1;
              res_d.status = STATUS_NOTHING;
            end
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          if (div_n == '0) begin
            res_we       = 1'b1;
            res_d.status = STATUS_TOO_SMALL;
            state_d      = ST_IDLE;
          end else begin
            cap_div = 1'b1;
            state_d = ST_MUL;
          end
        end
      end
      ST_MUL:  state_d = ST_BASE;
      ST_BASE: state_d = ST_FILL;
      ST_FILL: begin
        mem_we = 1'b1;
        if (fill_i_q == n_q - 1'b1) begin
          // Last slot written: the new slab goes live on the partial list.
          carve_done  = 1'b1;
          top_we      = 1'b1;
          top_wi      = frames_q[SW-1:0];
          top_wd      = '0;
          lop.p_push  = 1'b1;
          lop.push_id = frames_q[SW-1:0];
          state_d     = ST_POP_RD;
        end
      end
      ST_POP_RD: begin
        mem_re  = 1'b1;
        state_d = ST_POP_WR;
      end
      ST_POP_WR: begin
        top_we = 1'b1;
        top_wi = cur_q;
        top_wd = top_inc[TW-1:0];
        if (top_inc >= {1'b0, spp_q}) begin
          lop.p_pop   = 1'b1;
          lop.f_push  = 1'b1;
          lop.push_id = cur_q;
        end
        if (in_use_q != '1) begin
          in_use_d = in_use_q + 1'b1;
        end
        res_we               = 1'b1;
        res_d.object_address = 32'(rd_data_q);
        res_d.objects_in_use = in_use_d;
        state_d              = ST_IDLE;
      end
      ST_PUSH: begin
        top_we = 1'b1;
        top_wd = top_dec;
        mem_we = 1'b1;
        mem_wa = slot_idx(part_head, top_dec);
        mem_wd = AW'(freed_q);
        if (top_dec == '0) begin
          lop.p_pop   = 1'b1;
          lop.e_push  = 1'b1;
          lop.push_id = part_head;
        end
        if (in_use_q != '0) begin
          in_use_d = in_use_q - 1'b1;
        end
        res_we               = 1'b1;
        res_d.objects_in_use = in_use_d;
        state_d              = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Length updates; a push onto a list that is already at capacity is dropped.
  always_comb begin
    el_d = el_q - LW'(lop.e_pop);
    pl_d = pl_q - LW'(lop.p_pop);
    fl_d = fl_q - LW'(lop.f_pop);
    if (lop.e_push && el_q < LW'(MAX_SLABS)) el_d = el_q + 1'b1;
    if (lop.p_push && pl_q < LW'(MAX_SLABS)) pl_d = pl_q + 1'b1;
    if (lop.f_push && fl_q < LW'(MAX_SLABS)) fl_d = fl_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      el_q        <= '0;
      pl_q        <= '0;
      fl_q        <= '0;
      frames_q    <= '0;
      spp_q       <= '0;
      in_use_q    <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      el_q        <= el_d;
      pl_q        <= pl_d;
      fl_q        <= fl_d;
      in_use_q    <= in_use_d;
      res_valid_q <= res_we;
      if (carve_done) begin
        frames_q <= frames_q + 1'b1;
        spp_q    <= n_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (lop.e_push && el_q < LW'(MAX_SLABS)) empty_list_q[el_q[SW-1:0]] <= lop.push_id;
    if (lop.p_push && pl_q < LW'(MAX_SLABS)) part_list_q[pl_q[SW-1:0]]  <= lop.push_id;
    if (lop.f_push && fl_q < LW'(MAX_SLABS)) full_list_q[fl_q[SW-1:0]]  <= lop.push_id;
    if (top_we) slab_top_q[top_wi] <= top_wd;
    if (res_we) res_q <= res_d;
    if (start && !busy) freed_q <= req_i.freed_address;
    if (cap_div) n_q <= div_n;
    if (state_q == ST_POP_RD) cur_q <= part_head;
    if (state_q == ST_MUL) begin
      frame_off_q <= AW'(frames_q) * AW'(slab_bytes_q);
      osn_q       <= AW'(obj_size_q) * AW'(n_q);
    end
    if (state_q == ST_BASE) begin
      // First slot sits n objects below the frame end.
      fill_addr_q <= AW'(pool_base_q) + frame_off_q + AW'(slab_bytes_q) - osn_q;
      fill_i_q    <= '0;
    end else if (state_q == ST_FILL) begin
      fill_addr_q <= fill_addr_q + AW'(obj_size_q);
      fill_i_q    <= fill_i_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) slot_mem[mem_wa] <= mem_wd;
    if (mem_re) rd_data_q <= slot_mem[mem_ra];
  end

  assign busy           = (state_q != ST_IDLE);
  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

endmodule

>>> tb/sv/tb_slab_object_allocator.sv
// Self-checking testbench for the slab object allocator: drives alloc and release
// commands and APB register writes, and checks every result against a predictor.
// Depends on soa_pkg and the slab_object_allocator RTL.
`timescale 1ns / 100ps

class slab_scoreboard;
  localparam int NSLAB = 16;
  localparam int NOBJ  = 256;
  localparam int LEMPTY = 0, LPART = 1, LFULL = 2;

  logic [15:0] obj_size;
  logic [16:0] slab_sz;
  logic [10:0] hdr_sz;
  logic [3:0]  ptr_sz;
  logic [31:0] base_addr;

  logic [31:0] free_stack [NSLAB*NOBJ];
  bit          written [NSLAB*NOBJ];
  int unsigned given_out [NSLAB];
  int unsigned slot_cnt;
  int unsigned slab_list [3][NSLAB];
  int unsigned list_len [3];
  int unsigned carved;
  int unsigned live_objs;

  soa_pkg::rsp_t pending_rsp [$];
  int unsigned errors;
  int unsigned checked;
  int unsigned carves_seen, no_frame_seen, too_small_seen, nothing_seen;

  function new();
    obj_size = 64; slab_sz = 4096; hdr_sz = 48; ptr_sz = 8; base_addr = 0;
    foreach (given_out[i]) given_out[i] = 0;
    foreach (list_len[i]) list_len[i] = 0;
    slot_cnt = 0; carved = 0; live_objs = 0; errors = 0; checked = 0;
  endfunction

  function void write_reg(int idx, logic [31:0] val);
    case (idx)
      soa_pkg::REG_OBJECT_SIZE:   obj_size = val[15:0];
      soa_pkg::REG_SLAB_BYTES:    slab_sz = val[16:0];
      soa_pkg::REG_HEADER_BYTES:  hdr_sz = val[10:0];
      soa_pkg::REG_POINTER_BYTES: ptr_sz = val[3:0];
      soa_pkg::REG_POOL_BASE:     base_addr = val;
      default: ;
    endcase
  endfunction

  function void push_slab(int w, int unsigned s);
    if (list_len[w] < NSLAB) begin
      slab_list[w][list_len[w]] = s;
      list_len[w]++;
    end
  endfunction

  function int unsigned pop_slab(int w);
    list_len[w]--;
    return slab_list[w][list_len[w]];
  endfunction

  function int unsigned slots_fit();
    longint unsigned used, dv, n;
    used = hdr_sz + ptr_sz;
    dv = obj_size + ptr_sz;
    if (slab_sz <= used || dv == 0) return 0;
    n = (slab_sz - used) / dv;
    return (n > NOBJ) ? NOBJ : 32'(n);
  endfunction

  function int unsigned stack_pos(int unsigned s, int unsigned i);
    return (s % NSLAB) * NOBJ + ((i < NOBJ) ? i : NOBJ - 1);
  endfunction

  // True when the next allocate would read a stack entry that holds an address.
  // After the slot count grows, an older slab can run past the entries it owns.
  function bit alloc_reads_written();
    int unsigned s;
    if (list_len[LPART] > 0) s = slab_list[LPART][list_len[LPART]-1] % NSLAB;
    else if (list_len[LEMPTY] > 0) s = slab_list[LEMPTY][list_len[LEMPTY]-1] % NSLAB;
    else return 1'b1;
    return written[stack_pos(s, given_out[s])];
  endfunction

  function void note_request(soa_pkg::req_t rq);
    soa_pkg::rsp_t r;
    int unsigned s, n;
    logic [31:0] first;
    r.status = soa_pkg::STATUS_OK;
    r.object_address = '0;
    if (rq.cmd == soa_pkg::CMD_ALLOC) begin
      if (list_len[LPART] > 0) begin
      end else if (list_len[LEMPTY] > 0) begin
        s = pop_slab(LEMPTY);
        push_slab(LPART, s);
      end else if (carved >= NSLAB) begin
        r.status = soa_pkg::STATUS_NO_FRAME;
        no_frame_seen++;
      end else if (slots_fit() == 0) begin
        r.status = soa_pkg::STATUS_TOO_SMALL;
        too_small_seen++;
      end else begin
        n = slots_fit();
        s = carved++;
        carves_seen++;
        slot_cnt = n;
        first = base_addr + 32'(s) * 32'(slab_sz) + 32'(slab_sz) - 32'(obj_size) * 32'(n);
        for (int i = 0; i < n; i++) begin
          free_stack[stack_pos(s, i)] = first + 32'(i) * 32'(obj_size);
          written[stack_pos(s, i)] = 1'b1;
        end
        given_out[s] = 0;
        push_slab(LPART, s);
      end
      if (r.status == soa_pkg::STATUS_OK) begin
        s = slab_list[LPART][list_len[LPART]-1] % NSLAB;
        r.object_address = free_stack[stack_pos(s, given_out[s])];
        given_out[s]++;
        if (given_out[s] >= slot_cnt) begin
          void'(pop_slab(LPART));
          push_slab(LFULL, s);
        end
        if (live_objs < 8191) live_objs++;
      end
    end else begin
      if (list_len[LPART] > 0) begin
      end else if (list_len[LFULL] > 0) begin
        s = pop_slab(LFULL);
        push_slab(LPART, s);
      end else begin
        r.status = soa_pkg::STATUS_NOTHING;
        nothing_seen++;
      end
      if (r.status == soa_pkg::STATUS_OK) begin
        s = slab_list[LPART][list_len[LPART]-1] % NSLAB;
        if (given_out[s] > 0) given_out[s]--;
        free_stack[stack_pos(s, given_out[s])] = rq.freed_address;
        written[stack_pos(s, given_out[s])] = 1'b1;
        if (live_objs > 0) live_objs--;
        if (given_out[s] == 0) begin
          void'(pop_slab(LPART));
          push_slab(LEMPTY, s);
        end
      end
    end
    r.objects_in_use = live_objs[12:0];
    pending_rsp.push_back(r);
  endfunction

  function void check_result(soa_pkg::rsp_t got);
    soa_pkg::rsp_t want;
    if (pending_rsp.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result %p", got);
      return;
    end
    want = pending_rsp.pop_front();
    checked++;
    if (got.status !== want.status || got.object_address !== want.object_address ||
        got.objects_in_use !== want.objects_in_use) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: expected st=%0d addr=%h use=%0d got st=%0d addr=%h use=%0d",
                 want.status, want.object_address, want.objects_in_use,
                 got.status, got.object_address, got.objects_in_use);
    end
  endfunction
endclass

module tb_slab_object_allocator;
  import soa_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk_i, rst_ni, start, busy, result_valid_o;
  req_t        req_i;
  rsp_t        result_o;
  logic        psel, penable, pwrite, pready;
  logic [4:0]  paddr;
  logic [31:0] pwdata, prdata;

  slab_scoreboard sb;
  int unsigned idle_cycles;
  bit          allow_gaps;
  logic [31:0] live_addr [$];

  slab_object_allocator uut (.*);

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (result_valid_o) sb.check_result(result_o);
    if ((start && !busy) || result_valid_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", idle_cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    sb.write_reg(idx, val);
    @(posedge clk_i);
  endtask

  // Start stays high from one transfer to the next unless an idle burst comes between.
  task automatic send_cmd(logic cmd, logic [31:0] addr);
    req_t rq;
    if (allow_gaps && $urandom_range(0, 3) == 0) begin
      start <= 0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    rq.cmd = cmd; rq.freed_address = addr;
    start <= 1; req_i <= rq;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_request(rq);
  endtask

  task automatic do_alloc();
    send_cmd(CMD_ALLOC, 32'($urandom));
    live_addr.push_back(sb.pending_rsp[$].object_address);
  endtask

  // Releases mostly recycle a previously handed-out address, sometimes a foreign one.
  task automatic do_free();
    logic [31:0] a;
    int k;
    if (live_addr.size() > 0 && $urandom_range(0, 9) != 0) begin
      k = $urandom_range(0, live_addr.size() - 1);
      a = live_addr[k];
      live_addr.delete(k);
    end else a = $urandom;
    send_cmd(CMD_FREE, a);
  endtask

  // Waits until every result is in, then idles a while before any register write.
  task automatic drain();
    int n;
    n = 0;
    start <= 0;
    while (sb.pending_rsp.size() > 0 && n < 100000) begin
      @(posedge clk_i); n++;
    end
    repeat (300) @(posedge clk_i);
  endtask

  task automatic geometry(int os, int sbytes, int hb, int pb, logic [31:0] pbase);
    reg_write(REG_OBJECT_SIZE, os);
    reg_write(REG_SLAB_BYTES, sbytes);
    reg_write(REG_HEADER_BYTES, hb);
    reg_write(REG_POINTER_BYTES, pb);
    reg_write(REG_POOL_BASE, pbase);
  endtask

  task automatic random_phase(int count, int alloc_bias);
    for (int i = 0; i < count; i++)
      if ($urandom_range(0, 99) < alloc_bias && sb.alloc_reads_written()) do_alloc();
      else do_free();
  endtask

  initial begin
    sb = new();
    rst_ni = 0; start = 0; req_i = '0; psel = 0; penable = 0; pwrite = 0;
    paddr = '0; pwdata = '0; idle_cycles = 0; allow_gaps = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: nothing to release, then a too-small slab, then edge geometry.
    send_cmd(CMD_FREE, 32'hFFFF_FFFF);
    send_cmd(CMD_FREE, 32'h0);
    drain();
    geometry(65535, 256, 1024, 4, 32'hFFFF_FFFF);
    send_cmd(CMD_ALLOC, 0);
    drain();
    geometry(8, 256, 0, 4, 32'hFFFF_F000);
    for (int i = 0; i < 6; i++) do_alloc();
    do_free(); do_free();
    send_cmd(CMD_FREE, 32'hFFFF_FFFF);
    drain();
    // Geometry changed after carving: the shared slot count shrinks at the next carve.
    geometry(200, 1024, 16, 8, 32'h8000_0000);
    for (int i = 0; i < 8; i++) do_alloc();
    drain();

    allow_gaps = 1;
    // Small slabs so that all frames get taken and the no-frame case appears.
    random_phase(250, 70);
    drain();
    geometry($urandom_range(8, 300), $urandom_range(256, 2048), $urandom_range(0, 64),
             $urandom_range(4, 8), $urandom);
    random_phase(250, 45);
    drain();
    geometry($urandom_range(8, 65535), $urandom_range(256, 65536), $urandom_range(0, 1024),
             $urandom_range(4, 8), $urandom);
    random_phase(200, 55);
    drain();
    allow_gaps = 0;
    random_phase(180, 50);
    drain();

    $display("checked %0d results: %0d carves, %0d no-frame, %0d too-small, %0d empty releases",
             sb.checked, sb.carves_seen, sb.no_frame_seen, sb.too_small_seen, sb.nothing_seen);
    if (sb.errors == 0 && sb.pending_rsp.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d results outstanding", sb.errors, sb.pending_rsp.size());
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
